// File: hw/rtl/ita_pkg.sv
// shared types, constants and helpers of the integer to ascii formatter
`default_nettype none

package ita_pkg;

  localparam int WordW  = 32;
  localparam int ChrW   = 7;
  localparam int DigW   = 4;
  localparam int NDec   = 10;
  localparam int BcdW   = NDec * DigW;
  localparam int PosW   = $clog2(NDec);
  localparam int StepW  = $clog2(WordW);
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic OP_DEC = 1'b0;
  localparam logic OP_HEX = 1'b1;

  localparam logic [ChrW-1:0] CHR_MINUS = 7'h2d;
  localparam logic [ChrW-1:0] CHR_ZERO  = 7'h30;
  localparam logic [ChrW-1:0] CHR_A     = 7'h61;

  typedef struct packed {
    logic             hex;
    logic             neg;
    logic [WordW-1:0] mag;
  } ita_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIZE,
    ST_EMIT
  } ita_state_t;

  function automatic logic [ChrW-1:0] digit_char(input logic [DigW-1:0] d);
    logic [ChrW-1:0] dx;
    dx = {{(ChrW-DigW){1'b0}}, d};
    if (d < 4'd10) begin
      return CHR_ZERO + dx;
    end else begin
      return CHR_A + dx - 7'd10;
    end
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/integer_to_ascii_formatter.sv
// top level of the integer to ascii formatter
//
// Converts one 32-bit word per input transaction into ASCII characters, one
// character per output transaction, most significant digit first.
// in_op = 0 reads in_value as two's complement and prints it in decimal with
// a leading '-' when negative; in_op = 1 prints it as lower-case hex.
// No leading zeros; zero prints as a single '0'. out_last marks the final
// character of a number (1 to 11 characters per number).
// Both channels use valid/ready. A two-entry queue sits behind the input, so
// up to two words are taken while an earlier one is still being printed.
// Decimal words pass through the back end's shift-and-add-3 loop (one bit per
// cycle); hex words skip it. The single output register gives one character
// per cycle while out_ready is high. A stalled out_ready holds the current
// character and pauses character emission; the queue keeps accepting until
// full.
// Synchronous active-low reset empties the queue and drops out_valid.
`default_nettype none

module integer_to_ascii_formatter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_op,
  input  wire logic [31:0] in_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [6:0]       out_char_code,
  output logic             out_last
);
  import ita_pkg::*;

  ita_item_t front_item;
  ita_item_t back_item;
  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_not_empty;

  ita_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_op    (in_op),
    .in_value (in_value),
    .q_push   (q_push),
    .q_full   (q_full),
    .q_item   (front_item)
  );

  ita_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (back_item)
  );

  ita_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_not_empty   (q_not_empty),
    .q_item        (back_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char_code (out_char_code),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire

// File: hw/rtl/ita_front.sv
// front end: accepts a word and classifies it into mode, sign and magnitude
`default_nettype none

module ita_front (
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_op,
  input  wire logic [31:0]        in_value,
  output logic                    q_push,
  input  wire logic               q_full,
  output ita_pkg::ita_item_t      q_item
);
  import ita_pkg::*;

  logic is_neg;

  assign is_neg   = (in_op == OP_DEC) && in_value[WordW-1];
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.hex = (in_op == OP_HEX);
    q_item.neg = is_neg;
    // two's complement magnitude, the most negative word maps onto itself
    q_item.mag = is_neg ? (~in_value + 32'd1) : in_value;
  end

endmodule

`default_nettype wire

// File: hw/rtl/ita_queue.sv
// two-entry queue between the front end and the conversion back end
`default_nettype none

module ita_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire ita_pkg::ita_item_t  push_item,
  output logic                     full,
  input  wire logic                pop,
  output logic                     not_empty,
  output ita_pkg::ita_item_t       pop_item
);
  import ita_pkg::*;

  ita_item_t        mem_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full      = (cnt_r == QCntW'(QDepth));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ita_back.sv
// back end: shift-and-add-3 decimal conversion and character emission
`default_nettype none

module ita_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_not_empty,
  input  wire ita_pkg::ita_item_t  q_item,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [6:0]               out_char_code,
  output logic                     out_last
);
  import ita_pkg::*;

  ita_state_t       state_r, state_nxt;
  logic             neg_r, neg_nxt;
  logic             sign_pend_r, sign_pend_nxt;
  logic [WordW-1:0] shreg_r, shreg_nxt;
  logic [BcdW-1:0]  bcd_r, bcd_nxt;
  logic [BcdW-1:0]  bcd_adj;
  logic [StepW-1:0] step_r, step_nxt;
  logic [PosW-1:0]  pos_r, pos_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [ChrW-1:0]  out_char_r, out_char_nxt;
  logic             out_last_r, out_last_nxt;
  logic             load_out;
  logic [PosW-1:0]  top_pos;
  logic [DigW-1:0]  cur_dig;

  function automatic logic [BcdW-1:0] dabble(input logic [BcdW-1:0] b);
    logic [BcdW-1:0] r;
    r = b;
    for (int i = 0; i < NDec; i++) begin
      if (r[i*DigW +: DigW] >= 4'd5) begin
        r[i*DigW +: DigW] = r[i*DigW +: DigW] + 4'd3;
      end
    end
    return r;
  endfunction

  assign q_pop    = (state_r == ST_IDLE) && q_not_empty;
  assign load_out = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign cur_dig  = bcd_r[pos_r*DigW +: DigW];
  assign bcd_adj  = dabble(bcd_r);

  // index of the most significant nonzero digit, zero when all digits are zero
  always_comb begin
    top_pos = '0;
    for (int i = 0; i < NDec; i++) begin
      if (bcd_r[i*DigW +: DigW] != '0) begin
        top_pos = PosW'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_not_empty) begin
          state_nxt = q_item.hex ? ST_SIZE : ST_CONV;
        end
      end
      ST_CONV: begin
        if (step_r == StepW'(WordW - 1)) begin
          state_nxt = ST_SIZE;
        end
      end
      ST_SIZE: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (load_out && !sign_pend_r && pos_r == '0) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    neg_nxt       = neg_r;
    sign_pend_nxt = sign_pend_r;
    shreg_nxt     = shreg_r;
    bcd_nxt       = bcd_r;
    step_nxt      = step_r;
    pos_nxt       = pos_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (q_not_empty) begin
          neg_nxt   = q_item.neg;
          shreg_nxt = q_item.mag;
          step_nxt  = '0;
          // hex digits are the nibbles of the word itself
          bcd_nxt   = q_item.hex ? {{(BcdW-WordW){1'b0}}, q_item.mag} : '0;
        end
      end
      ST_CONV: begin
        bcd_nxt   = {bcd_adj[BcdW-2:0], shreg_r[WordW-1]};
        shreg_nxt = {shreg_r[WordW-2:0], 1'b0};
        step_nxt  = step_r + 1'b1;
      end
      ST_SIZE: begin
        pos_nxt       = top_pos;
        sign_pend_nxt = neg_r;
      end
      ST_EMIT: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          if (sign_pend_r) begin
            out_char_nxt  = CHR_MINUS;
            out_last_nxt  = 1'b0;
            sign_pend_nxt = 1'b0;
          end else begin
            out_char_nxt = digit_char(cur_dig);
            out_last_nxt = (pos_r == '0);
            if (pos_r != '0) begin
              pos_nxt = pos_r - 1'b1;
            end
          end
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      sign_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sign_pend_r <= sign_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    shreg_r    <= shreg_nxt;
    bcd_r      <= bcd_nxt;
    step_r     <= step_nxt;
    pos_r      <= pos_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;

endmodule

`default_nettype wire

// File: hw/rtl/ita_checker.sv
// port-level checks of the integer to ascii formatter and their bind
`default_nettype none

module ita_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [6:0] out_char_code,
  input wire logic       out_last
);
  import ita_pkg::*;

  // stalled character holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char_code) && $stable(out_last))
    else $error("output transaction changed while stalled");

  // a sign is always followed by at least one digit
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char_code == CHR_MINUS |-> !out_last)
    else $error("minus sign flagged as last character");

  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_char_code == CHR_MINUS
      || (out_char_code >= 7'h30 && out_char_code <= 7'h39)
      || (out_char_code >= 7'h61 && out_char_code <= 7'h66))
    else $error("illegal character code");

  // a sign can never be immediately followed by another sign
  a_no_double_minus: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_char_code == CHR_MINUS
      |=> !(out_valid && out_char_code == CHR_MINUS))
    else $error("two minus signs in a row");

endmodule

bind integer_to_ascii_formatter ita_checker u_ita_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_char_code (out_char_code),
  .out_last      (out_last)
);

`default_nettype wire
